// ===== sv/pws_pkg.sv =====
// ============================================================================
// pws_pkg: shared types and constants for per-task window statistics
// Sizes of the task table, the sample windows and the front/back request.
// ============================================================================
package pws_pkg;
    localparam int TASK_ENTRIES = 64;
    localparam int WINDOW_DEPTH = 16;
    localparam int METRICS      = 3;
    localparam int SLOT_W       = $clog2(TASK_ENTRIES);
    localparam int POS_W        = $clog2(WINDOW_DEPTH);
    localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int USE_W        = $clog2(TASK_ENTRIES + 1);
    localparam int WIN_W        = $clog2(TASK_ENTRIES * METRICS);
    localparam int ID_W         = 22;
    localparam int DATA_W       = 32;
    localparam int SUM_W        = DATA_W + POS_W + 1;
    localparam int MQ_DEPTH     = 2;
    localparam logic [DATA_W-1:0] TOLERANCE_RESET = 32'd100;
    localparam logic [1:0] OP_INVALID = 2'd3;

    // Request from the front (lookup) to the back (window arithmetic).
    typedef struct packed {
        logic              drop;      // invalid opcode or table full: no work
        logic              full_flag;
        logic              fresh;
        logic [1:0]        opcode;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] sample;
    } pws_req_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] average;
        logic [CNT_W-1:0]  count;
        logic              metric_periodic;
        logic              task_periodic;
        logic              fresh;
        logic              full_flag;
    } pws_res_t;
endpackage

// ===== sv/per_task_window_statistics_top.sv =====
// ============================================================================
// per_task_window_statistics_top: keyed sliding-window timing statistics
// Track per-task windows of response, execution and interval times.
// ============================================================================
// Usage:
//   Input channel: drive opcode, task_id and sample with push; a request is
//   taken when push is high and full is low. Result channel: while empty is
//   low the oldest result is on the result ports; pop takes it.
//   tolerance_we/tolerance_wdata write the periodicity tolerance (reset 100);
//   write it only while the block is idle.
//   Operation: one request is processed at a time in each half. The front
//   scans the key table one entry per cycle, then hands the request over.
//   The back loads the three window records, writes the sample, walks the
//   three windows one sample per cycle and runs a 37-step shift-subtract
//   divider. A dropped request skips the back's window work and division.
//   Front and back overlap through a two-entry request queue, so the
//   sustained rate is set by the slower of the key scan and the back end.
//   Results collect in a two-entry queue; when the receiver stalls, the
//   back holds its result and the front fills the request queue, then full
//   rises. Reset empties both queues and the task table at once.
// ============================================================================
module per_task_window_statistics_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 opcode,
    input  logic [pws_pkg::ID_W-1:0]   task_id,
    input  logic [pws_pkg::DATA_W-1:0] sample,
    input  logic                       tolerance_we,
    input  logic [pws_pkg::DATA_W-1:0] tolerance_wdata,
    output logic                       empty,
    input  logic                       pop,
    output logic [5:0]                 slot,
    output logic [31:0]                window_average,
    output logic [4:0]                 valid_count,
    output logic                       metric_periodic,
    output logic                       task_periodic,
    output logic                       new_task,
    output logic                       table_full
);
    import pws_pkg::*;

    logic [DATA_W-1:0] tolerance_reg;
    logic     f_valid, f_ready, b_valid, b_ready, r_valid, r_ready;
    pws_req_t f_req, b_req;
    pws_res_t r_res;

    // request queue between front and back
    pws_req_t rq_mem [MQ_DEPTH];
    logic     rq_wp_reg, rq_rp_reg;
    logic [1:0] rq_cnt_reg;
    // result queue
    pws_res_t oq_mem [MQ_DEPTH];
    logic     oq_wp_reg, oq_rp_reg;
    logic [1:0] oq_cnt_reg;

    pws_front u_front (
        .clk (clk), .rst_n (rst_n),
        .in_valid (push), .in_ready (f_ready),
        .opcode (opcode), .task_id (task_id), .sample (sample),
        .req_valid (f_valid), .req_ready (rq_cnt_reg != 2'(MQ_DEPTH)), .req (f_req)
    );

    pws_back u_back (
        .clk (clk), .rst_n (rst_n), .tolerance (tolerance_reg),
        .req_valid (b_valid), .req_ready (b_ready), .req (b_req),
        .res_valid (r_valid), .res_ready (r_ready), .res (r_res)
    );

    assign full    = !f_ready;
    assign b_valid = (rq_cnt_reg != '0);
    assign b_req   = rq_mem[rq_rp_reg];
    assign r_ready = (oq_cnt_reg != 2'(MQ_DEPTH));
    assign empty   = (oq_cnt_reg == '0);

    always_comb
    begin
        slot            = oq_mem[oq_rp_reg].slot;
        window_average  = oq_mem[oq_rp_reg].average;
        valid_count     = oq_mem[oq_rp_reg].count;
        metric_periodic = oq_mem[oq_rp_reg].metric_periodic;
        task_periodic   = oq_mem[oq_rp_reg].task_periodic;
        new_task        = oq_mem[oq_rp_reg].fresh;
        table_full      = oq_mem[oq_rp_reg].full_flag;
    end

    logic rq_in, rq_out, oq_in, oq_out;
    assign rq_in  = f_valid && (rq_cnt_reg != 2'(MQ_DEPTH));
    assign rq_out = b_valid && b_ready;
    assign oq_in  = r_valid && r_ready;
    assign oq_out = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (rq_in) rq_mem[rq_wp_reg] <= f_req;
        if (oq_in) oq_mem[oq_wp_reg] <= r_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOLERANCE_RESET;
            rq_wp_reg <= 1'b0; rq_rp_reg <= 1'b0; rq_cnt_reg <= '0;
            oq_wp_reg <= 1'b0; oq_rp_reg <= 1'b0; oq_cnt_reg <= '0;
        end
        else
        begin
            if (tolerance_we) tolerance_reg <= tolerance_wdata;
            if (rq_in)  rq_wp_reg <= !rq_wp_reg;
            if (rq_out) rq_rp_reg <= !rq_rp_reg;
            rq_cnt_reg <= rq_cnt_reg + 2'(rq_in) - 2'(rq_out);
            if (oq_in)  oq_wp_reg <= !oq_wp_reg;
            if (oq_out) oq_rp_reg <= !oq_rp_reg;
            oq_cnt_reg <= oq_cnt_reg + 2'(oq_in) - 2'(oq_out);
        end
    end

    ap_rq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cnt_reg <= 2'(MQ_DEPTH))
        else $error("request queue overflow");
    ap_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oq_cnt_reg <= 2'(MQ_DEPTH))
        else $error("result queue overflow");
    ap_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && table_full |-> slot == '0 && valid_count == '0)
        else $error("dropped request with payload");
endmodule

// ===== sv/pws_ram.sv =====
// ============================================================================
// pws_ram: generic single-port-write, single-read RAM
// One write and one registered read per cycle.
// ============================================================================
module pws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/pws_front.sv =====
// ============================================================================
// pws_front: task lookup and allocation
// Scan the key table one entry a cycle; a miss takes a fresh entry if free.
// ============================================================================
module pws_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 opcode,
    input  logic [pws_pkg::ID_W-1:0]   task_id,
    input  logic [pws_pkg::DATA_W-1:0] sample,
    output logic                       req_valid,
    input  logic                       req_ready,
    output pws_pkg::pws_req_t          req
);
    import pws_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [USE_W-1:0]  used_reg, used_next;
    logic [USE_W-1:0]  idx_reg, idx_next;
    logic [1:0]        op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [DATA_W-1:0] smp_reg;
    pws_req_t          req_reg, req_next;
    logic              rd_pending_reg, rd_pending_next;
    logic              key_we;
    logic [ID_W-1:0]   key_rdata;
    logic [SLOT_W-1:0] hit_slot_reg;

    pws_ram #(.WIDTH(ID_W), .DEPTH(TASK_ENTRIES)) u_keys (
        .clk   (clk),
        .we    (key_we),
        .waddr (used_reg[SLOT_W-1:0]),
        .wdata (id_reg),
        .raddr (idx_reg[SLOT_W-1:0]),
        .rdata (key_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign req_valid = (state_reg == ST_OUT);
    assign req       = req_reg;

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        idx_next        = idx_reg;
        req_next        = req_reg;
        rd_pending_next = 1'b0;
        key_we          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // idx_reg addresses the RAM; data of the previous index arrives now
                req_next.opcode = op_reg;
                req_next.sample = smp_reg;
                req_next.fresh  = 1'b0;
                req_next.full_flag = 1'b0;
                req_next.drop   = 1'b0;
                if (op_reg == OP_INVALID)
                begin
                    req_next.drop = 1'b1;
                    req_next.slot = '0;
                    state_next    = ST_OUT;
                end
                else if (rd_pending_reg && key_rdata == id_reg)
                begin
                    req_next.slot = hit_slot_reg;
                    state_next    = ST_OUT;
                end
                else if (idx_reg >= used_reg)
                begin
                    if (used_reg >= USE_W'(TASK_ENTRIES))
                    begin
                        req_next.drop      = 1'b1;
                        req_next.full_flag = 1'b1;
                        req_next.slot      = '0;
                    end
                    else
                    begin
                        key_we        = 1'b1;
                        req_next.slot = used_reg[SLOT_W-1:0];
                        req_next.fresh = 1'b1;
                        used_next     = used_reg + 1'b1;
                    end
                    state_next = ST_OUT;
                end
                else
                begin
                    idx_next        = idx_reg + 1'b1;
                    rd_pending_next = 1'b1;
                end
            end
            ST_OUT:
            begin
                if (req_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_reg       <= '0;
            idx_reg        <= '0;
            rd_pending_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            idx_reg        <= idx_next;
            rd_pending_reg <= rd_pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        hit_slot_reg <= idx_reg[SLOT_W-1:0];
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg  <= opcode;
            id_reg  <= task_id;
            smp_reg <= sample;
        end
    end

    ap_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= USE_W'(TASK_ENTRIES))
        else $error("task count beyond table size");
    ap_fresh_grows: assert property (@(posedge clk) disable iff (!rst_n)
        key_we |=> used_reg == $past(used_reg) + 1'b1)
        else $error("allocation without count advance");
    ap_full_no_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req.full_flag) |-> used_reg == USE_W'(TASK_ENTRIES))
        else $error("full flag with free entries");
endmodule

// ===== sv/pws_back.sv =====
// ============================================================================
// pws_back: window update and statistics
// Load the three window records, write the sample, walk three windows over
// their RAM, store the records back and divide sum by count.
// ============================================================================
module pws_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pws_pkg::DATA_W-1:0] tolerance,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  pws_pkg::pws_req_t          req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output pws_pkg::pws_res_t          res
);
    import pws_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_LOAD  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_WALK  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam int SAMP_DEPTH = TASK_ENTRIES * METRICS * WINDOW_DEPTH;
    localparam int SAMP_AW    = $clog2(SAMP_DEPTH);
    localparam int META_W     = POS_W + CNT_W;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DSTEP_W    = $clog2(DIV_STEPS + 1);

    logic [2:0]         state_reg, state_next;
    pws_req_t           rq_reg;
    // position and fill of the task's three windows while a request runs
    logic [POS_W-1:0]   pos_loc [METRICS];
    logic [CNT_W-1:0]   fill_loc [METRICS];
    logic [1:0]         ld_reg;       // record being loaded
    logic [1:0]         m_reg;        // metric being walked
    logic [CNT_W-1:0]   k_reg;        // sample index in walk
    logic               rd_v_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [DATA_W-1:0]  mn_reg, mx_reg;
    logic               tp_reg, mp_reg;
    logic [CNT_W-1:0]   sel_cnt_reg;
    logic [SUM_W-1:0]   quo_reg;
    logic [CNT_W:0]     rem_reg;
    logic [DSTEP_W-1:0] dstep_reg;

    logic [WIN_W-1:0]   wbase, wsel, wwalk, m_raddr;
    logic [POS_W-1:0]   newpos;
    logic [CNT_W-1:0]   cnt_walk;
    logic [POS_W-1:0]   ridx;
    logic               s_we;
    logic [SAMP_AW-1:0] s_waddr, s_raddr;
    logic [DATA_W-1:0]  s_rdata;
    logic [CNT_W:0]     rem_sh;
    logic               m_we;
    logic [META_W-1:0]  m_wdata, m_rdata;

    assign wbase   = WIN_W'(rq_reg.slot * METRICS);
    assign wsel    = wbase + WIN_W'(rq_reg.opcode);
    assign wwalk   = wbase + WIN_W'(m_reg);
    assign m_raddr = wbase + WIN_W'((ld_reg == 2'd3) ? 2'd0 : ld_reg);
    assign newpos  = pos_loc[rq_reg.opcode] + 1'b1;
    assign cnt_walk = fill_loc[m_reg];
    assign ridx    = pos_loc[m_reg] - k_reg[POS_W-1:0];
    assign s_we    = (state_reg == ST_WRITE);
    assign s_waddr = SAMP_AW'({wsel, newpos});
    assign s_raddr = SAMP_AW'({wwalk, ridx});
    assign rem_sh  = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
    // store each window record back as its walk finishes
    assign m_we    = (state_reg == ST_WALK) && (k_reg == cnt_walk) && !rd_v_reg;
    assign m_wdata = {pos_loc[m_reg], fill_loc[m_reg]};

    pws_ram #(.WIDTH(DATA_W), .DEPTH(SAMP_DEPTH)) u_samples (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (rq_reg.sample),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    pws_ram #(.WIDTH(META_W), .DEPTH(TASK_ENTRIES * METRICS)) u_meta (
        .clk   (clk),
        .we    (m_we),
        .waddr (wwalk),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_OUT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (req_valid) state_next = req.drop ? ST_OUT : ST_LOAD;
            ST_LOAD:  if (ld_reg == 2'd3) state_next = ST_WRITE;
            ST_WRITE: state_next = ST_WALK;
            ST_WALK:
            begin
                if (k_reg == cnt_walk && !rd_v_reg && m_reg == 2'd2)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:   if (dstep_reg == DSTEP_W'(DIV_STEPS)) state_next = ST_OUT;
            ST_OUT:   if (res_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                rq_reg   <= req;
                ld_reg   <= '0;
                m_reg    <= '0;
                k_reg    <= '0;
                rd_v_reg <= 1'b0;
                sum_reg  <= '0;
                mn_reg   <= '1;
                mx_reg   <= '0;
                tp_reg   <= 1'b0;
                mp_reg   <= 1'b0;
                sel_cnt_reg <= '0;
                quo_reg  <= '0;
                rem_reg  <= '0;
            end
            ST_LOAD:
            begin
                // a fresh entry starts with all three windows empty
                if (ld_reg != 2'd0)
                begin
                    pos_loc[ld_reg - 2'd1]  <= rq_reg.fresh ? '0 : m_rdata[META_W-1:CNT_W];
                    fill_loc[ld_reg - 2'd1] <= rq_reg.fresh ? '0 : m_rdata[CNT_W-1:0];
                end
                ld_reg <= ld_reg + 1'b1;
            end
            ST_WRITE:
            begin
                pos_loc[rq_reg.opcode] <= newpos;
                if (fill_loc[rq_reg.opcode] < CNT_W'(WINDOW_DEPTH))
                begin
                    fill_loc[rq_reg.opcode] <= fill_loc[rq_reg.opcode] + 1'b1;
                end
            end
            ST_WALK:
            begin
                // fold the sample read in the previous cycle
                if (rd_v_reg)
                begin
                    sum_reg <= sum_reg + SUM_W'(s_rdata);
                    if (s_rdata < mn_reg) mn_reg <= s_rdata;
                    if (s_rdata > mx_reg) mx_reg <= s_rdata;
                end
                if (k_reg != cnt_walk)
                begin
                    k_reg    <= k_reg + 1'b1;
                    rd_v_reg <= 1'b1;
                end
                else if (!rd_v_reg)
                begin
                    // window finished
                    if (cnt_walk != '0 && (mx_reg - mn_reg) < tolerance)
                    begin
                        tp_reg <= 1'b1;
                        if (m_reg == rq_reg.opcode) mp_reg <= 1'b1;
                    end
                    if (m_reg == rq_reg.opcode)
                    begin
                        sel_cnt_reg <= cnt_walk;
                        quo_reg     <= sum_reg;
                    end
                    m_reg   <= m_reg + 1'b1;
                    k_reg   <= '0;
                    sum_reg <= '0;
                    mn_reg  <= '1;
                    mx_reg  <= '0;
                    rem_reg <= '0;
                    dstep_reg <= '0;
                end
                else
                begin
                    rd_v_reg <= 1'b0;
                end
            end
            ST_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (dstep_reg != DSTEP_W'(DIV_STEPS))
                begin
                    if (rem_sh >= {1'b0, sel_cnt_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, sel_cnt_reg};
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
                    end
                    dstep_reg <= dstep_reg + 1'b1;
                end
            end
            ST_OUT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res = '0;
        res.full_flag = rq_reg.full_flag;
        if (!rq_reg.drop)
        begin
            res.slot            = rq_reg.slot;
            res.average         = quo_reg[DATA_W-1:0];
            res.count           = sel_cnt_reg;
            res.metric_periodic = mp_reg;
            res.task_periodic   = tp_reg;
            res.fresh           = rq_reg.fresh;
        end
    end

    ap_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WALK |-> k_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("walk index past window");
    ap_mp_tp: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.metric_periodic |-> res.task_periodic)
        else $error("metric periodic without task periodic");
    ap_cnt_nz: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !rq_reg.drop |-> res.count != '0)
        else $error("empty selected window after push");
endmodule
